// ===== sv/ray_obb_slab_test_unit_macros.svh =====
// Assertion macros shared by the checker of the ray to box slab test unit.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef RAY_OBB_SLAB_TEST_UNIT_MACROS_SVH
`define RAY_OBB_SLAB_TEST_UNIT_MACROS_SVH

// Same-cycle implication, reset masked.
`define ROBB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, reset masked.
`define ROBB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/robb_pkg.sv =====
// Package of the ray to box slab test unit: word format, payload structs,
// codes and small helpers. Used by every module of the block.
`default_nettype none

package robb_pkg;

    // Word format of vectors, bounds and distances.
    localparam int WORD_BITS   = 48;
    localparam int DIST_BITS   = 47;
    localparam int THRESH_BITS = 17;
    localparam int KIND_BITS   = 3;
    localparam int CFG_IDX_BITS = 3;

    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    // Item kinds.
    localparam logic [KIND_BITS-1:0] KIND_ORIGIN = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_DIR    = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_AXIS_X = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_AXIS_Y = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_AXIS_Z = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_BOX    = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_X  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_Y  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_Z  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_X  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_Y  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_Z  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESH = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FAR    = 3'd7;

    typedef struct packed {
        logic [KIND_BITS-1:0]        kind;
        logic signed [WORD_BITS-1:0] vec_x;
        logic signed [WORD_BITS-1:0] vec_y;
        logic signed [WORD_BITS-1:0] vec_z;
    } in_req_t;

    typedef struct packed {
        logic                 hit;
        logic [DIST_BITS-1:0] distance;
    } out_req_t;

    // Command to the serial multiply and divide unit.
    typedef struct packed {
        logic start;
        logic div;
    } arith_cmd_t;

    // Magnitude of a signed word; the most negative word maps to 2^(W-1).
    function automatic logic [WORD_BITS-1:0] mag(input logic signed [WORD_BITS-1:0] a);
        logic [WORD_BITS-1:0] u;
        u = a;
        return a[WORD_BITS-1] ? WORD_BITS'(~u + 1'b1) : u;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ray_obb_slab_test_unit.sv =====
// Ray against oriented box, slab method, in signed fixed point. Requests of
// kinds origin, direction and the three box axes are stored on arrival and
// give no result. A box position request runs the test: per axis six
// bit-serial products and, for a slab that is not parallel, two serial
// divisions, all through the one shared multiply and divide unit. A test
// ends sooner when it misses early. The input is stalled while a test runs.
// Depends on robb_pkg and robb_muldiv.
`default_nettype none

module ray_obb_slab_test_unit
    import robb_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire in_req_t                    in_data,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output out_req_t                        out_data,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [WORD_BITS-1:0]       cfg_data
);

    localparam int W = WORD_BITS;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_MUL_GO   = 8'b0000_0010,
        S_MUL_WAIT = 8'b0000_0100,
        S_CHECK    = 8'b0000_1000,
        S_DIV_GO   = 8'b0001_0000,
        S_DIV_WAIT = 8'b0010_0000,
        S_NARROW   = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic signed [W-1:0] org_reg [3];
    logic signed [W-1:0] dir_reg [3];
    logic signed [W-1:0] axes_reg [3][3];
    logic signed [W-1:0] delta_reg [3];
    logic signed [W-1:0] cfg_min_reg [3];
    logic signed [W-1:0] cfg_max_reg [3];
    logic [THRESH_BITS-1:0] thresh_reg;
    logic [DIST_BITS-1:0]   far_reg;

    logic [1:0]          ax_reg, ax_next;
    logic [1:0]          c_reg, c_next;
    logic                dot_f_reg, dot_f_next;
    logic                div_hi_reg, div_hi_next;
    logic                hit_reg, hit_next;
    logic signed [W-1:0] acc_reg, acc_next;
    logic signed [W-1:0] e_reg, e_next;
    logic signed [W-1:0] f_reg, f_next;
    logic signed [W-1:0] t1_reg, t1_next;
    logic signed [W-1:0] tmin_reg, tmin_next;
    logic signed [W-1:0] tmax_reg, tmax_next;
    logic                out_valid_reg, out_valid_next;
    out_req_t            out_data_reg, out_data_next;

    arith_cmd_t          cmd;
    logic signed [W-1:0] opa, opb;
    logic                arith_done;
    logic signed [W-1:0] arith_res;

    logic                in_accept;
    logic signed [W-1:0] acc_sum;
    logic signed [W-1:0] t_lo, t_hi, nmin, nmax;

    function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
        begin
            return s[W] ? WORD_MIN : WORD_MAX;
        end
        return s[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1])
        begin
            return s[W] ? WORD_MIN : WORD_MAX;
        end
        return s[W-1:0];
    endfunction

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Shared serial arithmetic unit.
    robb_muldiv #(
        .FRAC_BITS (FRAC_BITS)
    ) u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .opa    (opa),
        .opb    (opb),
        .done   (arith_done),
        .result (arith_res)
    );

    // Operand selection for the unit.
    always_comb
    begin
        cmd.start = (state_reg == S_MUL_GO) || (state_reg == S_DIV_GO);
        cmd.div   = (state_reg == S_DIV_GO);
        if (state_reg == S_DIV_GO)
        begin
            opa = sat_add(e_reg, div_hi_reg ? cfg_max_reg[ax_reg] : cfg_min_reg[ax_reg]);
            opb = f_reg;
        end
        else
        begin
            opa = axes_reg[ax_reg][c_reg];
            opb = dot_f_reg ? dir_reg[c_reg] : delta_reg[c_reg];
        end
    end

    // Interval narrowing terms.
    always_comb
    begin
        acc_sum = sat_add(acc_reg, arith_res);
        t_lo    = (t1_reg > arith_res) ? arith_res : t1_reg;
        t_hi    = (t1_reg > arith_res) ? t1_reg : arith_res;
        nmax    = (t_hi < tmax_reg) ? t_hi : tmax_reg;
        nmin    = (t_lo > tmin_reg) ? t_lo : tmin_reg;
    end

    // Test sequencer.
    always_comb
    begin
        state_next     = state_reg;
        ax_next        = ax_reg;
        c_next         = c_reg;
        dot_f_next     = dot_f_reg;
        div_hi_next    = div_hi_reg;
        hit_next       = hit_reg;
        acc_next       = acc_reg;
        e_next         = e_reg;
        f_next         = f_reg;
        t1_next        = t1_reg;
        tmin_next      = tmin_reg;
        tmax_next      = tmax_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && in_data.kind == KIND_BOX)
                begin
                    ax_next    = 2'd0;
                    c_next     = 2'd0;
                    dot_f_next = 1'b0;
                    acc_next   = '0;
                    tmin_next  = '0;
                    tmax_next  = W'(far_reg);
                    state_next = S_MUL_GO;
                end
            end
            S_MUL_GO:
            begin
                state_next = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (arith_done)
                begin
                    if (c_reg == 2'd2)
                    begin
                        c_next   = 2'd0;
                        acc_next = '0;
                        if (dot_f_reg)
                        begin
                            f_next     = acc_sum;
                            state_next = S_CHECK;
                        end
                        else
                        begin
                            e_next     = acc_sum;
                            dot_f_next = 1'b1;
                            state_next = S_MUL_GO;
                        end
                    end
                    else
                    begin
                        acc_next   = acc_sum;
                        c_next     = c_reg + 2'd1;
                        state_next = S_MUL_GO;
                    end
                end
            end
            S_CHECK:
            begin
                // Slab not parallel: divide; otherwise the origin must lie inside.
                if (mag(f_reg) > W'(thresh_reg))
                begin
                    div_hi_next = 1'b0;
                    state_next  = S_DIV_GO;
                end
                else if (cfg_min_reg[ax_reg] > e_reg || cfg_max_reg[ax_reg] < e_reg)
                begin
                    hit_next   = 1'b0;
                    state_next = S_DONE;
                end
                else if (ax_reg == 2'd2)
                begin
                    hit_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ax_next    = ax_reg + 2'd1;
                    dot_f_next = 1'b0;
                    state_next = S_MUL_GO;
                end
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (arith_done)
                begin
                    if (div_hi_reg)
                    begin
                        state_next = S_NARROW;
                    end
                    else
                    begin
                        t1_next     = arith_res;
                        div_hi_next = 1'b1;
                        state_next  = S_DIV_GO;
                    end
                end
            end
            S_NARROW:
            begin
                // The second quotient is still held at the unit's output.
                tmin_next = nmin;
                tmax_next = nmax;
                if (nmax < nmin)
                begin
                    hit_next   = 1'b0;
                    state_next = S_DONE;
                end
                else if (ax_reg == 2'd2)
                begin
                    hit_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ax_next    = ax_reg + 2'd1;
                    dot_f_next = 1'b0;
                    state_next = S_MUL_GO;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.hit      = hit_reg;
                    out_data_next.distance = hit_reg ? tmin_reg[DIST_BITS-1:0] : '0;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ax_reg        <= '0;
            c_reg         <= '0;
            dot_f_reg     <= 1'b0;
            div_hi_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            acc_reg       <= '0;
            e_reg         <= '0;
            f_reg         <= '0;
            t1_reg        <= '0;
            tmin_reg      <= '0;
            tmax_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ax_reg        <= ax_next;
            c_reg         <= c_next;
            dot_f_reg     <= dot_f_next;
            div_hi_reg    <= div_hi_next;
            hit_reg       <= hit_next;
            acc_reg       <= acc_next;
            e_reg         <= e_next;
            f_reg         <= f_next;
            t1_reg        <= t1_next;
            tmin_reg      <= tmin_next;
            tmax_reg      <= tmax_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // Stored vectors; the box position is turned into deltas on arrival.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                org_reg[i]   <= '0;
                dir_reg[i]   <= '0;
                delta_reg[i] <= '0;
                for (int j = 0; j < 3; j++)
                begin
                    axes_reg[i][j] <= '0;
                end
            end
        end
        else if (in_accept)
        begin
            case (in_data.kind)
                KIND_ORIGIN:
                begin
                    org_reg[0] <= in_data.vec_x;
                    org_reg[1] <= in_data.vec_y;
                    org_reg[2] <= in_data.vec_z;
                end
                KIND_DIR:
                begin
                    dir_reg[0] <= in_data.vec_x;
                    dir_reg[1] <= in_data.vec_y;
                    dir_reg[2] <= in_data.vec_z;
                end
                KIND_AXIS_X:
                begin
                    axes_reg[0][0] <= in_data.vec_x;
                    axes_reg[0][1] <= in_data.vec_y;
                    axes_reg[0][2] <= in_data.vec_z;
                end
                KIND_AXIS_Y:
                begin
                    axes_reg[1][0] <= in_data.vec_x;
                    axes_reg[1][1] <= in_data.vec_y;
                    axes_reg[1][2] <= in_data.vec_z;
                end
                KIND_AXIS_Z:
                begin
                    axes_reg[2][0] <= in_data.vec_x;
                    axes_reg[2][1] <= in_data.vec_y;
                    axes_reg[2][2] <= in_data.vec_z;
                end
                KIND_BOX:
                begin
                    delta_reg[0] <= sat_sub(in_data.vec_x, org_reg[0]);
                    delta_reg[1] <= sat_sub(in_data.vec_y, org_reg[1]);
                    delta_reg[2] <= sat_sub(in_data.vec_z, org_reg[2]);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cfg_min_reg[i] <= -W'(65536);
                cfg_max_reg[i] <= W'(65536);
            end
            thresh_reg <= THRESH_BITS'(66);
            far_reg    <= DIST_BITS'(64'd6553600000);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_X:  cfg_min_reg[0] <= cfg_data;
                CFG_MIN_Y:  cfg_min_reg[1] <= cfg_data;
                CFG_MIN_Z:  cfg_min_reg[2] <= cfg_data;
                CFG_MAX_X:  cfg_max_reg[0] <= cfg_data;
                CFG_MAX_Y:  cfg_max_reg[1] <= cfg_data;
                CFG_MAX_Z:  cfg_max_reg[2] <= cfg_data;
                CFG_THRESH: thresh_reg     <= cfg_data[THRESH_BITS-1:0];
                CFG_FAR:    far_reg        <= cfg_data[DIST_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/robb_muldiv.sv =====
// Bit-serial fixed-point multiplier and restoring divider, shared by all
// products and quotients of the slab test. Depends on robb_pkg.
`default_nettype none

module robb_muldiv
    import robb_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire arith_cmd_t                  cmd,
    input  wire logic signed [WORD_BITS-1:0] opa,
    input  wire logic signed [WORD_BITS-1:0] opb,
    output logic                             done,
    output logic signed [WORD_BITS-1:0]      result
);

    localparam int W  = WORD_BITS;
    localparam int NB = WORD_BITS + FRAC_BITS;
    localparam int CW = $clog2(NB + 1);
    localparam logic [CW-1:0] MUL_LAST = CW'(W - 1);
    localparam logic [CW-1:0] DIV_LAST = CW'(NB - 1);

    logic                   busy_reg, fin_reg, done_reg, div_reg, neg_reg;
    logic [CW-1:0]          cnt_reg;
    logic [W-1:0]           x_reg;
    logic [2*W-1:0]         p_reg;
    logic [W-1:0]           r_reg;
    logic signed [W-1:0]    res_reg;

    logic [W:0]             mul_sum;
    logic [2*W-1:0]         mul_p_next;
    logic [W:0]             rem_shift;
    logic                   rem_ge;
    logic [W-1:0]           rem_next;
    logic [2*W-1:0]         div_p_next;
    logic [2*W-1:0]         mag_out;
    logic                   ovf;
    logic [W-1:0]           low_word;
    logic signed [W-1:0]    sat_val;

    // One multiply step: add the multiplicand on a set bit, shift right.
    always_comb
    begin
        mul_sum    = {1'b0, p_reg[2*W-1:W]} + (p_reg[0] ? {1'b0, x_reg} : {(W+1){1'b0}});
        mul_p_next = {mul_sum, p_reg[W-1:1]};
    end

    // One divide step: bring down the next dividend bit, subtract if it fits.
    always_comb
    begin
        rem_shift  = {r_reg, p_reg[NB-1]};
        rem_ge     = rem_shift >= {1'b0, x_reg};
        rem_next   = rem_ge ? W'(rem_shift - {1'b0, x_reg}) : rem_shift[W-1:0];
        div_p_next = {p_reg[2*W-1:NB], p_reg[NB-2:0], rem_ge};
    end

    // Saturate the final magnitude to the word range and apply the sign.
    always_comb
    begin
        mag_out  = div_reg ? p_reg : (p_reg >> FRAC_BITS);
        low_word = mag_out[W-1:0];
        ovf      = (|mag_out[2*W-1:W])
                 || (mag_out[W-1] && (!neg_reg || (|mag_out[W-2:0])));
        if (ovf)
        begin
            sat_val = neg_reg ? WORD_MIN : WORD_MAX;
        end
        else
        begin
            sat_val = neg_reg ? W'(~low_word + 1'b1) : low_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            div_reg  <= 1'b0;
            neg_reg  <= 1'b0;
            cnt_reg  <= '0;
            x_reg    <= '0;
            p_reg    <= '0;
            r_reg    <= '0;
            res_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (cmd.start && !busy_reg && !fin_reg)
            begin
                // Load magnitudes; operands are a*b or a/b.
                busy_reg <= 1'b1;
                div_reg  <= cmd.div;
                neg_reg  <= opa[W-1] ^ opb[W-1];
                cnt_reg  <= '0;
                r_reg    <= '0;
                if (cmd.div)
                begin
                    x_reg <= mag(opb);
                    p_reg <= {{(2*W-NB){1'b0}}, mag(opa), {FRAC_BITS{1'b0}}};
                end
                else
                begin
                    x_reg <= mag(opa);
                    p_reg <= {{W{1'b0}}, mag(opb)};
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (div_reg)
                begin
                    p_reg <= div_p_next;
                    r_reg <= rem_next;
                end
                else
                begin
                    p_reg <= mul_p_next;
                end
                if (cnt_reg == (div_reg ? DIV_LAST : MUL_LAST))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                res_reg  <= sat_val;
                done_reg <= 1'b1;
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

// ===== sv/robb_checker.sv =====
// Port-level checker of the ray to box slab test unit, bound to the top level.
// Depends on robb_pkg and the assertion macros header.
`default_nettype none

`include "ray_obb_slab_test_unit_macros.svh"

module robb_checker
    import robb_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     in_valid,
    input wire logic     in_stall,
    input wire in_req_t  in_data,
    input wire logic     out_valid,
    input wire logic     out_stall,
    input wire out_req_t out_data
);

    // A miss always reports zero distance.
    `ROBB_ASSERT_NOW(a_miss_zero, out_valid && !out_data.hit, out_data.distance == '0, "miss with nonzero distance")

    // A stored vector request leaves the input open in the next cycle.
    `ROBB_ASSERT_NEXT(a_store_fast, in_valid && !in_stall && in_data.kind != KIND_BOX, !in_stall, "input closed after a store request")

    // A box request starts a test, which closes the input.
    `ROBB_ASSERT_NEXT(a_box_busy, in_valid && !in_stall && in_data.kind == KIND_BOX, in_stall, "input open while a test runs")

    // A stalled result holds.
    `ROBB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind ray_obb_slab_test_unit robb_checker u_robb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
